[hdl/rtcm_pkg.sv]
// Shared constants for the remote teleop command mapper.
`default_nettype none
package rtcm_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_LO  = 3'd0,
        CFG_TILT_HI  = 3'd1,
        CFG_PAN_LO   = 3'd2,
        CFG_PAN_HI   = 3'd3,
        CFG_BTN_EN   = 3'd4,
        CFG_ACCEL_EN = 3'd5
    } t_cfg_idx;

    // button bit positions
    localparam int BTN_2     = 0;
    localparam int BTN_1     = 1;
    localparam int BTN_B     = 2;
    localparam int BTN_A     = 3;
    localparam int BTN_MINUS = 4;
    localparam int BTN_LEFT  = 8;
    localparam int BTN_RIGHT = 9;
    localparam int BTN_DOWN  = 10;
    localparam int BTN_UP    = 11;
    localparam int BTN_PLUS  = 12;

    localparam logic [11:0] SPEED_MAX   = 12'd1600;
    localparam logic [11:0] SPEED_MIN   = 12'd100;
    localparam logic [11:0] SPEED_STEP  = 12'd10;
    localparam logic [11:0] SPEED_FLOOR = 12'd110;
    localparam logic [10:0] SPEED_RST   = 11'd300;
    localparam logic [5:0]  TURN_MAX    = 6'd30;
    localparam logic [5:0]  TURN_MIN    = 6'd8;
    localparam logic [4:0]  TURN_RST    = 5'd20;

    localparam logic [7:0] ACC_LOW  = 8'd110;
    localparam logic [7:0] ACC_HIGH = 8'd140;

    localparam logic signed [17:0] ANGLE_STEP   = 18'sd500;
    localparam logic signed [17:0] MARGIN_WIDE  = 18'sd2000;
    localparam logic signed [17:0] MARGIN_ACCEL = 18'sd300;
    localparam logic signed [17:0] ANGLE_LIMIT  = 18'sd18000;

    localparam logic signed [15:0] TILT_LO_RST = -16'sd4500;
    localparam logic signed [15:0] TILT_HI_RST = 16'sd4500;
    localparam logic signed [15:0] PAN_LO_RST  = -16'sd15000;
    localparam logic signed [15:0] PAN_HI_RST  = 16'sd15000;

endpackage
`default_nettype wire

[hdl/remote_teleop_command_mapper_unit.sv]
// Remote teleop command mapper: buttons and accelerometer to drive and pan/tilt commands.
// An accepted word passes the input register, then the result register, before o_out_valid rises.
// One word per cycle unless i_out_stall holds; the input register takes a word while a result waits.
// State update is a single pass of compares and adds between the two registers.
// Reset (synchronous, active low) clears both valids, loads register defaults,
// mode 0, speed 300, turn 20, pan and tilt targets 0.
`default_nettype none
module remote_teleop_command_mapper_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rtcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rtcm_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [15:0]                    i_button_mask,
    input  wire logic [7:0]                     i_accel_x,
    input  wire logic [7:0]                     i_accel_y,
    input  wire logic signed [15:0]             i_pan_measured,
    input  wire logic signed [15:0]             i_tilt_measured,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [11:0]                  o_drive_speed,
    output logic signed [5:0]                   o_turn_rate,
    output logic signed [15:0]                  o_tilt_target,
    output logic signed [15:0]                  o_pan_target,
    output logic                                o_mode,
    output logic [10:0]                         o_speed_magnitude,
    output logic [4:0]                          o_turn_magnitude
);
    import rtcm_pkg::*;

    logic signed [15:0] r_tilt_lo, r_tilt_hi, r_pan_lo, r_pan_hi;
    logic               r_btn_en, r_accel_en;

    logic               r_mode, n_mode;
    logic [10:0]        r_speed, n_speed;
    logic [4:0]         r_turn, n_turn;
    logic signed [15:0] r_tilt, n_tilt, r_pan, n_pan;

    logic               r_in_valid;
    logic [15:0]        r_btn;
    logic [7:0]         r_ax, r_ay;
    logic signed [15:0] r_pan_m, r_tilt_m;

    logic               r_out_valid;
    logic signed [11:0] r_drive, n_drive;
    logic signed [5:0]  r_rate, n_rate;

    logic               w_adv, w_take;
    logic signed [17:0] w_tilt, w_pan, w_tilt_m, w_pan_m;
    logic signed [17:0] w_tlo, w_thi, w_plo, w_phi;
    logic signed [11:0] w_spd;
    logic signed [5:0]  w_trn;
    logic [11:0]        w_sp;
    logic [5:0]         w_tn;
    logic               w_ay_lo, w_ay_hi, w_ax_lo, w_ax_hi;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_tilt_m = 18'(r_tilt_m);
    assign w_pan_m  = 18'(r_pan_m);
    assign w_tlo    = 18'(r_tilt_lo);
    assign w_thi    = 18'(r_tilt_hi);
    assign w_plo    = 18'(r_pan_lo);
    assign w_phi    = 18'(r_pan_hi);
    assign w_spd    = $signed({1'b0, r_speed});
    assign w_trn    = $signed({1'b0, r_turn});
    assign w_ay_lo  = r_ay < ACC_LOW;
    assign w_ay_hi  = r_ay > ACC_HIGH;
    assign w_ax_lo  = r_ax < ACC_LOW;
    assign w_ax_hi  = r_ax > ACC_HIGH;

    always_comb begin
        n_mode  = r_mode;
        n_drive = '0;
        n_rate  = '0;
        w_tilt  = 18'(r_tilt);
        w_pan   = 18'(r_pan);
        if (r_btn_en) begin
            if (r_btn[BTN_A]) begin
                n_mode = 1'b0;
            end else if (r_btn[BTN_B]) begin
                n_mode = 1'b1;
            end
        end

        if (!n_mode) begin
            if (r_btn_en) begin
                if (r_btn[BTN_UP]) begin
                    n_drive = w_spd;
                end else if (r_btn[BTN_DOWN]) begin
                    n_drive = -w_spd;
                end
                if (r_btn[BTN_LEFT]) n_rate = w_trn;
                if (r_btn[BTN_RIGHT]) n_rate = -w_trn;
            end
            if (r_accel_en) begin
                if (w_ay_lo) begin
                    if (w_tilt - ANGLE_STEP > w_tlo + MARGIN_ACCEL) w_tilt = w_tilt - ANGLE_STEP;
                end else if (w_ay_hi) begin
                    if (w_tilt + ANGLE_STEP < w_thi - MARGIN_ACCEL) w_tilt = w_tilt + ANGLE_STEP;
                end
                if (w_ax_lo) begin
                    if (w_pan - ANGLE_STEP > w_plo + MARGIN_WIDE) w_pan = w_pan - ANGLE_STEP;
                end else if (w_ax_hi) begin
                    if (w_pan + ANGLE_STEP < w_phi - MARGIN_WIDE) w_pan = w_pan + ANGLE_STEP;
                end
            end
        end else begin
            if (r_btn_en) begin
                if (r_btn[BTN_UP]) begin
                    if (w_tilt_m + ANGLE_STEP < w_thi - MARGIN_WIDE) w_tilt = w_tilt + ANGLE_STEP;
                end else if (r_btn[BTN_DOWN]) begin
                    if (w_tilt_m - ANGLE_STEP > w_tlo + MARGIN_WIDE) w_tilt = w_tilt - ANGLE_STEP;
                end
                if (r_btn[BTN_LEFT]) begin
                    if (w_pan_m - ANGLE_STEP > w_plo + MARGIN_WIDE) w_pan = w_pan - ANGLE_STEP;
                end else if (r_btn[BTN_RIGHT]) begin
                    if (w_pan_m + ANGLE_STEP < w_phi - MARGIN_WIDE) w_pan = w_pan + ANGLE_STEP;
                end
            end
            if (r_accel_en) begin
                if (w_ay_lo) begin
                    n_drive = -w_spd;
                end else if (w_ay_hi) begin
                    n_drive = w_spd;
                end
                if (w_ax_lo) begin
                    n_rate = w_trn;
                end else if (w_ax_hi) begin
                    n_rate = -w_trn;
                end
            end
        end

        if (w_tilt > ANGLE_LIMIT) w_tilt = ANGLE_LIMIT;
        if (w_tilt < -ANGLE_LIMIT) w_tilt = -ANGLE_LIMIT;
        if (w_pan > ANGLE_LIMIT) w_pan = ANGLE_LIMIT;
        if (w_pan < -ANGLE_LIMIT) w_pan = -ANGLE_LIMIT;
        n_tilt = w_tilt[15:0];
        n_pan  = w_pan[15:0];

        w_sp = {1'b0, r_speed};
        w_tn = {1'b0, r_turn};
        if (r_btn_en) begin
            if (r_btn[BTN_PLUS]) begin
                w_sp = (w_sp + SPEED_STEP > SPEED_MAX) ? SPEED_MAX : w_sp + SPEED_STEP;
            end
            if (r_btn[BTN_MINUS]) begin
                w_sp = (w_sp < SPEED_FLOOR) ? SPEED_MIN : w_sp - SPEED_STEP;
            end
            if (r_btn[BTN_1]) begin
                w_tn = (w_tn >= TURN_MAX) ? TURN_MAX : w_tn + 6'd1;
            end
            if (r_btn[BTN_2]) begin
                w_tn = (w_tn <= TURN_MIN) ? TURN_MIN : w_tn - 6'd1;
            end
        end
        n_speed = w_sp[10:0];
        n_turn  = w_tn[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_lo  <= TILT_LO_RST;
            r_tilt_hi  <= TILT_HI_RST;
            r_pan_lo   <= PAN_LO_RST;
            r_pan_hi   <= PAN_HI_RST;
            r_btn_en   <= 1'b1;
            r_accel_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TILT_LO:  r_tilt_lo  <= $signed(i_cfg_data);
                CFG_TILT_HI:  r_tilt_hi  <= $signed(i_cfg_data);
                CFG_PAN_LO:   r_pan_lo   <= $signed(i_cfg_data);
                CFG_PAN_HI:   r_pan_hi   <= $signed(i_cfg_data);
                CFG_BTN_EN:   r_btn_en   <= i_cfg_data[0];
                CFG_ACCEL_EN: r_accel_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_speed     <= SPEED_RST;
            r_turn      <= TURN_RST;
            r_tilt      <= '0;
            r_pan       <= '0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_speed     <= n_speed;
                r_turn      <= n_turn;
                r_tilt      <= n_tilt;
                r_pan       <= n_pan;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_btn    <= i_button_mask;
            r_ax     <= i_accel_x;
            r_ay     <= i_accel_y;
            r_pan_m  <= i_pan_measured;
            r_tilt_m <= i_tilt_measured;
        end
        if (w_adv) begin
            r_drive <= n_drive;
            r_rate  <= n_rate;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_speed     = r_drive;
    assign o_turn_rate       = r_rate;
    assign o_tilt_target     = r_tilt;
    assign o_pan_target      = r_pan;
    assign o_mode            = r_mode;
    assign o_speed_magnitude = r_speed;
    assign o_turn_magnitude  = r_turn;

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed >= SPEED_MIN[10:0] && r_speed <= SPEED_MAX[10:0])
        else $error("speed setting out of range");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_turn >= TURN_MIN[4:0] && r_turn <= TURN_MAX[4:0])
        else $error("turn setting out of range");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        18'(r_tilt) <= ANGLE_LIMIT && 18'(r_tilt) >= -ANGLE_LIMIT
        && 18'(r_pan) <= ANGLE_LIMIT && 18'(r_pan) >= -ANGLE_LIMIT)
        else $error("target angle out of range");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced word did not reach result register");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room available");

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the remote teleop command mapper unit.
`timescale 1ns / 1ps
module testbench;
    import rtcm_pkg::*;

    localparam int TGT_STEP   = 500;
    localparam int TGT_LIMIT  = 18000;
    localparam int EDGE_WIDE  = 2000;
    localparam int EDGE_ACCEL = 300;
    localparam int AXIS_LOW   = 110;
    localparam int AXIS_HIGH  = 140;
    localparam int SPD_HI     = 1600;
    localparam int SPD_LO     = 100;
    localparam int SPD_INC    = 10;
    localparam int TRN_HI     = 30;
    localparam int TRN_LO     = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [15:0] M_2     = 16'h1 << BTN_2;
    localparam logic [15:0] M_1     = 16'h1 << BTN_1;
    localparam logic [15:0] M_B     = 16'h1 << BTN_B;
    localparam logic [15:0] M_A     = 16'h1 << BTN_A;
    localparam logic [15:0] M_MINUS = 16'h1 << BTN_MINUS;
    localparam logic [15:0] M_LEFT  = 16'h1 << BTN_LEFT;
    localparam logic [15:0] M_RIGHT = 16'h1 << BTN_RIGHT;
    localparam logic [15:0] M_DOWN  = 16'h1 << BTN_DOWN;
    localparam logic [15:0] M_UP    = 16'h1 << BTN_UP;
    localparam logic [15:0] M_PLUS  = 16'h1 << BTN_PLUS;

    typedef struct {
        logic [15:0]        buttons;
        logic [7:0]         ax;
        logic [7:0]         ay;
        logic signed [15:0] pan_m;
        logic signed [15:0] tilt_m;
    } t_remote_word;

    typedef struct {
        logic signed [11:0] speed;
        logic signed [5:0]  turn;
        logic signed [15:0] tilt;
        logic signed [15:0] pan;
        logic               mode;
        logic [10:0]        speed_mag;
        logic [4:0]         turn_mag;
    } t_command;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic [15:0] i_button_mask = '0;
    logic [7:0] i_accel_x = 8'd125;
    logic [7:0] i_accel_y = 8'd125;
    logic signed [15:0] i_pan_measured = '0;
    logic signed [15:0] i_tilt_measured = '0;
    logic i_out_stall = 1'b0;
    logic o_cfg_ready, o_in_stall, o_out_valid, o_mode;
    logic signed [11:0] o_drive_speed;
    logic signed [5:0] o_turn_rate;
    logic signed [15:0] o_tilt_target, o_pan_target;
    logic [10:0] o_speed_magnitude;
    logic [4:0] o_turn_magnitude;

    // predictor state and register copies
    int lim_tilt_lo = -4500;
    int lim_tilt_hi = 4500;
    int lim_pan_lo = -15000;
    int lim_pan_hi = 15000;
    bit btn_en = 1'b1;
    bit acc_en = 1'b1;
    bit mdl_mode = 1'b0;
    int mdl_speed = 300;
    int mdl_turn = 20;
    int mdl_tilt = 0;
    int mdl_pan = 0;

    t_command cmd_expected[$];
    int errors = 0;
    bit idle_on = 1'b1;
    bit stall_on = 1'b1;
    int hold_len = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    remote_teleop_command_mapper_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_button_mask(i_button_mask),
        .i_accel_x(i_accel_x),
        .i_accel_y(i_accel_y),
        .i_pan_measured(i_pan_measured),
        .i_tilt_measured(i_tilt_measured),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_drive_speed(o_drive_speed),
        .o_turn_rate(o_turn_rate),
        .o_tilt_target(o_tilt_target),
        .o_pan_target(o_pan_target),
        .o_mode(o_mode),
        .o_speed_magnitude(o_speed_magnitude),
        .o_turn_magnitude(o_turn_magnitude)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int clamp_target(input int a);
        if (a > TGT_LIMIT) return TGT_LIMIT;
        if (a < -TGT_LIMIT) return -TGT_LIMIT;
        return a;
    endfunction

    function automatic t_command map_command(input t_remote_word w);
        t_command c;
        int spd, trn, pan_m, tilt_m, ax, ay;
        spd = 0;
        trn = 0;
        pan_m = w.pan_m;
        tilt_m = w.tilt_m;
        ax = w.ax;
        ay = w.ay;
        if (btn_en) begin
            if (w.buttons[BTN_A]) mdl_mode = 1'b0;
            else if (w.buttons[BTN_B]) mdl_mode = 1'b1;
        end
        if (!mdl_mode) begin
            if (btn_en) begin
                if (w.buttons[BTN_UP]) spd = mdl_speed;
                else if (w.buttons[BTN_DOWN]) spd = -mdl_speed;
                if (w.buttons[BTN_LEFT]) trn = mdl_turn;
                if (w.buttons[BTN_RIGHT]) trn = -mdl_turn;
            end
            if (acc_en) begin
                if (ay < AXIS_LOW) begin
                    if (mdl_tilt - TGT_STEP > lim_tilt_lo + EDGE_ACCEL) mdl_tilt -= TGT_STEP;
                end else if (ay > AXIS_HIGH) begin
                    if (mdl_tilt + TGT_STEP < lim_tilt_hi - EDGE_ACCEL) mdl_tilt += TGT_STEP;
                end
                if (ax < AXIS_LOW) begin
                    if (mdl_pan - TGT_STEP > lim_pan_lo + EDGE_WIDE) mdl_pan -= TGT_STEP;
                end else if (ax > AXIS_HIGH) begin
                    if (mdl_pan + TGT_STEP < lim_pan_hi - EDGE_WIDE) mdl_pan += TGT_STEP;
                end
            end
        end else begin
            if (btn_en) begin
                if (w.buttons[BTN_UP]) begin
                    if (tilt_m + TGT_STEP < lim_tilt_hi - EDGE_WIDE) mdl_tilt += TGT_STEP;
                end else if (w.buttons[BTN_DOWN]) begin
                    if (tilt_m - TGT_STEP > lim_tilt_lo + EDGE_WIDE) mdl_tilt -= TGT_STEP;
                end
                if (w.buttons[BTN_LEFT]) begin
                    if (pan_m - TGT_STEP > lim_pan_lo + EDGE_WIDE) mdl_pan -= TGT_STEP;
                end else if (w.buttons[BTN_RIGHT]) begin
                    if (pan_m + TGT_STEP < lim_pan_hi - EDGE_WIDE) mdl_pan += TGT_STEP;
                end
            end
            if (acc_en) begin
                if (ay < AXIS_LOW) spd = -mdl_speed;
                else if (ay > AXIS_HIGH) spd = mdl_speed;
                if (ax < AXIS_LOW) trn = mdl_turn;
                else if (ax > AXIS_HIGH) trn = -mdl_turn;
            end
        end
        mdl_tilt = clamp_target(mdl_tilt);
        mdl_pan = clamp_target(mdl_pan);
        if (btn_en) begin
            if (w.buttons[BTN_PLUS]) mdl_speed = (mdl_speed + SPD_INC > SPD_HI) ?
                SPD_HI : mdl_speed + SPD_INC;
            if (w.buttons[BTN_MINUS]) mdl_speed = (mdl_speed - SPD_INC < SPD_LO) ?
                SPD_LO : mdl_speed - SPD_INC;
            if (w.buttons[BTN_1]) mdl_turn = (mdl_turn + 1 > TRN_HI) ? TRN_HI : mdl_turn + 1;
            if (w.buttons[BTN_2]) mdl_turn = (mdl_turn - 1 < TRN_LO) ? TRN_LO : mdl_turn - 1;
        end
        c.speed = spd[11:0];
        c.turn = trn[5:0];
        c.tilt = mdl_tilt[15:0];
        c.pan = mdl_pan[15:0];
        c.mode = mdl_mode;
        c.speed_mag = mdl_speed[10:0];
        c.turn_mag = mdl_turn[4:0];
        return c;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || pick < 65) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_remote_word mk_word(input logic [15:0] m, input int ax, input int ay,
                                             input int pan, input int tilt);
        t_remote_word w;
        w.buttons = m;
        w.ax = ax[7:0];
        w.ay = ay[7:0];
        w.pan_m = pan[15:0];
        w.tilt_m = tilt[15:0];
        return w;
    endfunction

    function automatic int rand_angle();
        if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? TGT_LIMIT : -TGT_LIMIT;
        return int'($urandom_range(0, 2 * TGT_LIMIT)) - TGT_LIMIT;
    endfunction

    function automatic int rand_axis();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return $urandom_range(AXIS_LOW, AXIS_HIGH);
        if (pick < 55) return $urandom_range(0, AXIS_LOW - 1);
        if (pick < 70) return $urandom_range(AXIS_HIGH + 1, 255);
        return $urandom_range(0, 255);
    endfunction

    function automatic t_remote_word rand_word();
        logic [15:0] m;
        m = '0;
        if ($urandom_range(0, 99) < 25) begin
            m = 16'($urandom);
        end else begin
            if ($urandom_range(0, 99) < 8) m |= M_A;
            if ($urandom_range(0, 99) < 8) m |= M_B;
            if ($urandom_range(0, 99) < 25) m |= M_UP;
            if ($urandom_range(0, 99) < 25) m |= M_DOWN;
            if ($urandom_range(0, 99) < 25) m |= M_LEFT;
            if ($urandom_range(0, 99) < 25) m |= M_RIGHT;
            if ($urandom_range(0, 99) < 10) m |= M_PLUS;
            if ($urandom_range(0, 99) < 10) m |= M_MINUS;
            if ($urandom_range(0, 99) < 10) m |= M_1;
            if ($urandom_range(0, 99) < 10) m |= M_2;
        end
        return mk_word(m, rand_axis(), rand_axis(), rand_angle(), rand_angle());
    endfunction

    // leaves valid high after acceptance; next call or drain decides what follows
    task automatic send_word(input t_remote_word w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_button_mask <= w.buttons;
        i_accel_x <= w.ax;
        i_accel_y <= w.ay;
        i_pan_measured <= w.pan_m;
        i_tilt_measured <= w.tilt_m;
        do @(posedge i_clk); while (o_in_stall);
        cmd_expected.push_back(map_command(w));
    endtask

    task automatic drain_commands();
        i_in_valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_word(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TILT_LO:  lim_tilt_lo = int'($signed(data));
            CFG_TILT_HI:  lim_tilt_hi = int'($signed(data));
            CFG_PAN_LO:   lim_pan_lo = int'($signed(data));
            CFG_PAN_HI:   lim_pan_hi = int'($signed(data));
            CFG_BTN_EN:   btn_en = data[0];
            CFG_ACCEL_EN: acc_en = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int tlo, input int thi, input int plo, input int phi,
                              input bit ben, input bit aen);
        drain_commands();
        cfg_word(CFG_TILT_LO, tlo[15:0]);
        cfg_word(CFG_TILT_HI, thi[15:0]);
        cfg_word(CFG_PAN_LO, plo[15:0]);
        cfg_word(CFG_PAN_HI, phi[15:0]);
        cfg_word(CFG_BTN_EN, {15'd0, ben});
        cfg_word(CFG_ACCEL_EN, {15'd0, aen});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, exp_v, got_v);
        end
    endtask

    task automatic check_command();
        t_command e;
        if (cmd_expected.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: result word with none pending", $realtime);
        end else begin
            e = cmd_expected.pop_front();
            compare_field("drive_speed", e.speed, o_drive_speed);
            compare_field("turn_rate", e.turn, o_turn_rate);
            compare_field("tilt_target", e.tilt, o_tilt_target);
            compare_field("pan_target", e.pan, o_pan_target);
            compare_field("mode", {31'd0, e.mode}, {31'd0, o_mode});
            compare_field("speed_magnitude", {21'd0, e.speed_mag}, {21'd0, o_speed_magnitude});
            compare_field("turn_magnitude", {27'd0, e.turn_mag}, {27'd0, o_turn_magnitude});
        end
    endtask

    // result side: checks accepted words and drives the stall
    always @(posedge i_clk) begin
        int pick;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_command();
            pick = $urandom_range(0, 99);
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                hold_len = hold_len - 1;
            end else if (!stall_on) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else if (pick < 75) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic test_directed();
        send_word(mk_word(16'h0, 125, 125, 0, 0));
        send_word(mk_word(M_UP, 125, 125, 0, 0));
        send_word(mk_word(M_DOWN, 125, 125, 0, 0));
        send_word(mk_word(M_UP | M_DOWN, 125, 125, 0, 0));
        send_word(mk_word(M_LEFT, 125, 125, 0, 0));
        send_word(mk_word(M_RIGHT, 125, 125, 0, 0));
        send_word(mk_word(M_LEFT | M_RIGHT, 125, 125, 0, 0));
        send_word(mk_word(16'h0, 125, 0, 0, 0));
        send_word(mk_word(16'h0, 0, 255, 0, 0));
        send_word(mk_word(16'h0, 109, 141, 0, 0));
        send_word(mk_word(16'h0, 110, 140, 0, 0));
        send_word(mk_word(16'h0, 141, 109, 0, 0));
        send_word(mk_word(M_PLUS, 125, 125, 0, 0));
        send_word(mk_word(M_MINUS, 125, 125, 0, 0));
        send_word(mk_word(M_PLUS | M_MINUS, 125, 125, 0, 0));
        send_word(mk_word(M_1, 125, 125, 0, 0));
        send_word(mk_word(M_2, 125, 125, 0, 0));
        send_word(mk_word(M_1 | M_2, 125, 125, 0, 0));
        send_word(mk_word(M_A | M_B, 125, 125, 0, 0));
        send_word(mk_word(M_B, 125, 125, 0, 0));
        send_word(mk_word(M_UP, 125, 125, 0, 0));
        send_word(mk_word(M_DOWN, 125, 125, 0, -18000));
        send_word(mk_word(M_LEFT | M_RIGHT, 125, 125, 0, 0));
        send_word(mk_word(M_RIGHT, 125, 125, 18000, 0));
        send_word(mk_word(M_RIGHT, 255, 0, -5000, 0));
        send_word(mk_word(16'hFFFF, 0, 255, -18000, 18000));
    endtask

    task automatic test_setting_limits();
        repeat (140) send_word(mk_word(M_PLUS, 125, 125, 0, 0));
        send_word(mk_word(M_PLUS | M_MINUS, 125, 125, 0, 0));
        repeat (160) send_word(mk_word(M_MINUS, 125, 125, 0, 0));
        send_word(mk_word(M_PLUS | M_MINUS, 125, 125, 0, 0));
        repeat (25) send_word(mk_word(M_1, 125, 125, 0, 0));
        send_word(mk_word(M_1 | M_2, 125, 125, 0, 0));
        repeat (25) send_word(mk_word(M_2, 125, 125, 0, 0));
        send_word(mk_word(M_1 | M_2, 125, 125, 0, 0));
    endtask

    // stuck encoder in mode 1 pushes the targets into the output clamp
    task automatic test_target_saturation();
        set_config(-18000, 18000, -18000, 18000, 1'b1, 1'b1);
        send_word(mk_word(M_B, 125, 125, 0, 0));
        repeat (40) send_word(mk_word(M_UP | M_LEFT, 125, 125, 18000, -18000));
        repeat (80) send_word(mk_word(M_DOWN | M_RIGHT, 125, 125, -18000, 18000));
        send_word(mk_word(M_A, 0, 0, 0, 0));
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_len = 80;
        repeat (40) send_word(rand_word());
        idle_on = 1'b1;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(rand_word());
    endtask

    task automatic test_random();
        set_config(-4500, 4500, -15000, 15000, 1'b1, 1'b1);
        run_random(200);
        set_config(-18000, 18000, -18000, 18000, 1'b1, 1'b1);
        run_random(200);
        set_config(18000, -18000, 18000, -18000, 1'b1, 1'b1);
        run_random(150);
        repeat (3) begin
            set_config(rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                       $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            run_random(100);
        end
        set_config(-4500, 4500, -15000, 15000, 1'b0, 1'b1);
        run_random(150);
        set_config(-9000, 9000, -16000, 16000, 1'b1, 1'b0);
        run_random(150);
        set_config(-4500, 4500, -15000, 15000, 1'b0, 1'b0);
        run_random(100);
        idle_on = 1'b0;
        stall_on = 1'b0;
        set_config(-6000, 6000, -17000, 17000, 1'b1, 1'b1);
        run_random(150);
        idle_on = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_setting_limits();
        test_target_saturation();
        test_backpressure();
        test_random();
        drain_commands();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && cmd_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
